/* hw/rtl/pjd_pkg.sv */
`timescale 1ns / 1ps

package pjd_pkg;

  localparam int NUM_JOINTS = 32;
  localparam int JOINT_AW   = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  localparam int JOINT_W  = 5;
  localparam int POS_W    = 16;
  localparam int GAIN_W   = 24;
  localparam int MARGIN_W = 15;
  localparam int RATE_W   = 16;
  localparam int PERIOD_W = 24;
  localparam int SUM_W    = 32;
  localparam int MEM_W    = POS_W + SUM_W;
  localparam int V_W      = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd2;

  localparam logic [POS_W-1:0]    NEUTRAL_DRIVE = 16'h8000;
  localparam logic [POS_W-1:0]    DRIVE_TOP     = 16'd65534;
  localparam logic [RATE_W-1:0]   RESET_RATE    = 16'd500;
  localparam logic [PERIOD_W-1:0] RESET_PERIOD  = 24'd33554;

  typedef struct packed {
    logic capture;
    logic load;
    logic mul1;
    logic mul2;
    logic sum1;
    logic sum2;
    logic sum3;
    logic clamp;
    logic emit;
  } pjd_cmd_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } pjd_cfg_wr_t;

endpackage

/* hw/rtl/pjd_sample_if.sv */
`timescale 1ns / 1ps

interface pjd_sample_if;
  import pjd_pkg::*;

  logic                valid;
  logic                ready;
  logic [JOINT_W-1:0]  joint;
  logic [POS_W-1:0]    position;
  logic [POS_W-1:0]    target;
  logic [GAIN_W-1:0]   gain_p;
  logic [GAIN_W-1:0]   gain_d;
  logic [GAIN_W-1:0]   gain_i;
  logic [MARGIN_W-1:0] min_drive;
  logic [MARGIN_W-1:0] friction_offset;

  modport source (
    output valid, joint, position, target, gain_p, gain_d, gain_i, min_drive,
           friction_offset,
    input  ready
  );

  modport sink (
    input  valid, joint, position, target, gain_p, gain_d, gain_i, min_drive,
           friction_offset,
    output ready
  );
endinterface

/* hw/rtl/pjd_drive_if.sv */
`timescale 1ns / 1ps

interface pjd_drive_if;
  import pjd_pkg::*;

  logic               valid;
  logic               ready;
  logic [JOINT_W-1:0] joint_out;
  logic [POS_W-1:0]   drive;

  modport source (output valid, joint_out, drive, input ready);
  modport sink (input valid, joint_out, drive, output ready);
endinterface

/* hw/rtl/pjd_cfg_if.sv */
`timescale 1ns / 1ps

interface pjd_cfg_if;
  import pjd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/pid_joint_drive_with_friction_comp.sv */
`timescale 1ns / 1ps

// channel     dir  handshake      word
// sample_in   in   valid/ready    joint, position, target, gains, min_drive, friction_offset
// drive_out   out  valid/ready    joint_out, drive
// cfg         in   valid/ready    index, data (0 enable, 1 sample_rate, 2 sample_period)
//
// one sample at a time: the controller walks one word at a time through load,
// two multiply steps, three add steps, clamp and friction
// result word sits in an output register; the next sample is taken while it waits
// a stalled output holds the controller in its last step until the register frees
// rst is synchronous; per-joint state reads as reset through valid bits, no clear pass
// cfg is always ready

module pid_joint_drive_with_friction_comp (
  input logic         clk,
  input logic         rst,
  pjd_sample_if.sink  sample_in,
  pjd_drive_if.source drive_out,
  pjd_cfg_if.sink     cfg
);
  import pjd_pkg::*;

  pjd_cmd_t    cmd;
  pjd_cfg_wr_t cfg_wr;

  assign cfg.ready   = 1'b1;
  assign cfg_wr.we   = cfg.valid;
  assign cfg_wr.idx  = cfg.index;
  assign cfg_wr.data = cfg.data;

  pjd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (drive_out.valid),
    .out_ready (drive_out.ready),
    .cmd       (cmd)
  );

  pjd_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_wr          (cfg_wr),
    .joint           (sample_in.joint),
    .position        (sample_in.position),
    .target          (sample_in.target),
    .gain_p          (sample_in.gain_p),
    .gain_d          (sample_in.gain_d),
    .gain_i          (sample_in.gain_i),
    .min_drive       (sample_in.min_drive),
    .friction_offset (sample_in.friction_offset),
    .joint_out       (drive_out.joint_out),
    .drive           (drive_out.drive)
  );

endmodule

/* hw/rtl/pjd_ram.sv */
`timescale 1ns / 1ps

module pjd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/pjd_ctrl.sv */
`timescale 1ns / 1ps

module pjd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output pjd_pkg::pjd_cmd_t  cmd
);
  import pjd_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_MUL1  = 4'd2;
  localparam logic [3:0] ST_MUL2  = 4'd3;
  localparam logic [3:0] ST_SUM1  = 4'd4;
  localparam logic [3:0] ST_SUM2  = 4'd5;
  localparam logic [3:0] ST_SUM3  = 4'd6;
  localparam logic [3:0] ST_CLAMP = 4'd7;
  localparam logic [3:0] ST_FRIC  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_SUM1;
      end
      ST_SUM1: begin
        cmd.sum1   = 1'b1;
        state_next = ST_SUM2;
      end
      ST_SUM2: begin
        cmd.sum2   = 1'b1;
        state_next = ST_SUM3;
      end
      ST_SUM3: begin
        cmd.sum3   = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_FRIC;
      end
      ST_FRIC: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = (out_valid && !out_ready) || cmd.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/pjd_datapath.sv */
`timescale 1ns / 1ps

module pjd_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  pjd_pkg::pjd_cmd_t              cmd,
  input  pjd_pkg::pjd_cfg_wr_t           cfg_wr,
  input  logic [pjd_pkg::JOINT_W-1:0]    joint,
  input  logic [pjd_pkg::POS_W-1:0]      position,
  input  logic [pjd_pkg::POS_W-1:0]      target,
  input  logic [pjd_pkg::GAIN_W-1:0]     gain_p,
  input  logic [pjd_pkg::GAIN_W-1:0]     gain_d,
  input  logic [pjd_pkg::GAIN_W-1:0]     gain_i,
  input  logic [pjd_pkg::MARGIN_W-1:0]   min_drive,
  input  logic [pjd_pkg::MARGIN_W-1:0]   friction_offset,
  output logic [pjd_pkg::JOINT_W-1:0]    joint_out,
  output logic [pjd_pkg::POS_W-1:0]      drive
);
  import pjd_pkg::*;

  localparam logic signed [V_W-1:0] NEUTRAL_Q = V_W'({NEUTRAL_DRIVE, 16'h0000});

  // configuration
  logic                enable;
  logic [RATE_W-1:0]   sample_rate;
  logic [PERIOD_W-1:0] sample_period;

  // captured word
  logic [JOINT_W-1:0]  joint_q;
  logic [JOINT_AW-1:0] addr_q;
  logic                in_range_q;
  logic [POS_W-1:0]    pos_q;
  logic [POS_W-1:0]    tgt_q;
  logic [GAIN_W-1:0]   kp_q;
  logic [GAIN_W-1:0]   kd_q;
  logic [GAIN_W-1:0]   ki_q;
  logic [MARGIN_W-1:0] mn_q;
  logic [MARGIN_W-1:0] fr_q;

  // per-joint state
  logic [NUM_JOINTS-1:0] valid;
  logic [MEM_W-1:0]      rdata;
  logic [MEM_W-1:0]      wdata;
  logic                  we;

  // load step
  logic [POS_W-1:0]        prev;
  logic signed [SUM_W-1:0] old_sum;
  logic signed [16:0]      err;
  logic signed [16:0]      diff;
  logic signed [33:0]      sum_wide;
  logic signed [SUM_W-1:0] new_sum;

  logic signed [16:0]      err_q;
  logic                    diff_neg_q;
  logic [POS_W-1:0]        diff_mag_q;
  logic signed [SUM_W-1:0] sum_q;

  // multiply steps
  logic signed [32:0] sum_x;
  logic signed [41:0] p_q;
  logic [31:0]        rd_q;
  logic [47:0]        k_q;
  logic [31:0]        m_q;
  logic               sum_neg_q;
  logic [55:0]        dmag_q;
  logic [55:0]        ih_q;
  logic [55:0]        il_q;

  // add steps
  logic [56:0]           imag_q;
  logic signed [V_W-1:0] dterm_q;
  logic signed [V_W-1:0] s1_q;
  logic signed [V_W-1:0] iterm_q;
  logic signed [V_W-1:0] s2_q;
  logic signed [V_W-1:0] v_q;

  // clamp and friction
  logic signed [V_W-1:0] lo;
  logic signed [V_W-1:0] hi;
  logic [31:0]           vc_q;
  logic signed [33:0]    dv;
  logic signed [33:0]    fq;
  logic                  near;
  logic [POS_W-1:0]      drive_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      sample_rate   <= RESET_RATE;
      sample_period <= RESET_PERIOD;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.idx)
        REG_ENABLE:        enable        <= cfg_wr.data[0];
        REG_SAMPLE_RATE:   sample_rate   <= cfg_wr.data[RATE_W-1:0];
        REG_SAMPLE_PERIOD: sample_period <= cfg_wr.data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      joint_q    <= joint;
      addr_q     <= JOINT_AW'(joint);
      in_range_q <= (32'(joint) < 32'(NUM_JOINTS));
      pos_q      <= position;
      tgt_q      <= target;
      kp_q       <= gain_p;
      kd_q       <= gain_d;
      ki_q       <= gain_i;
      mn_q       <= min_drive;
      fr_q       <= friction_offset;
    end
  end

  pjd_ram #(
    .WIDTH (MEM_W),
    .DEPTH (NUM_JOINTS)
  ) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr_q),
    .wdata (wdata),
    .re    (cmd.capture),
    .raddr (JOINT_AW'(joint)),
    .rdata (rdata)
  );

  // untouched joints read as reset values
  always_comb begin
    if (valid[addr_q]) begin
      prev    = rdata[MEM_W-1:SUM_W];
      old_sum = $signed(rdata[SUM_W-1:0]);
    end else begin
      prev    = NEUTRAL_DRIVE;
      old_sum = '0;
    end
    err      = $signed({1'b0, tgt_q}) - $signed({1'b0, pos_q});
    diff     = $signed({1'b0, prev}) - $signed({1'b0, pos_q});
    sum_wide = 34'(old_sum) + 34'(err);
    if (!sum_wide[33] && (sum_wide[32:31] != 2'b00)) begin
      new_sum = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (sum_wide[33] && (sum_wide[32:31] != 2'b11)) begin
      new_sum = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      new_sum = sum_wide[SUM_W-1:0];
    end
  end

  assign we    = cmd.load && in_range_q;
  assign wdata = {pos_q, new_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_q      <= err;
      sum_q      <= new_sum;
      diff_neg_q <= diff[16];
      diff_mag_q <= diff[16] ? POS_W'(-diff) : POS_W'(diff);
    end
  end

  assign sum_x = 33'(sum_q);

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p_q       <= $signed({1'b0, kp_q}) * err_q;
      rd_q      <= sample_rate * diff_mag_q;
      k_q       <= ki_q * sample_period;
      sum_neg_q <= sum_q[SUM_W-1];
      m_q       <= sum_q[SUM_W-1] ? 32'(-sum_x) : 32'(sum_x);
    end
    if (cmd.mul2) begin
      dmag_q <= kd_q * rd_q;
      ih_q   <= m_q * k_q[47:24];
      il_q   <= m_q * k_q[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum1) begin
      imag_q  <= 57'(ih_q) + 57'(il_q[55:24]);
      dterm_q <= diff_neg_q ? -$signed(V_W'(dmag_q)) : $signed(V_W'(dmag_q));
      s1_q    <= {{(V_W-42){p_q[41]}}, p_q} + NEUTRAL_Q;
    end
    if (cmd.sum2) begin
      iterm_q <= sum_neg_q ? -$signed(V_W'(imag_q)) : $signed(V_W'(imag_q));
      s2_q    <= s1_q + dterm_q;
    end
    if (cmd.sum3) begin
      v_q <= s2_q + iterm_q;
    end
  end

  assign lo = $signed(V_W'({mn_q, 16'h0000}));
  assign hi = $signed(V_W'({DRIVE_TOP - {1'b0, mn_q}, 16'h0000}));

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      if (v_q < lo) begin
        vc_q <= 32'(lo);
      end else if (v_q > hi) begin
        vc_q <= 32'(hi);
      end else begin
        vc_q <= 32'(v_q);
      end
    end
  end

  // friction push away from neutral
  always_comb begin
    dv = $signed({2'b00, vc_q}) - $signed(34'({NEUTRAL_DRIVE, 16'h0000}));
    fq = $signed(34'({fr_q, 16'h0000}));
    if (dv[33]) begin
      near = (dv > -fq);
    end else begin
      near = (dv < fq);
    end
    if (near) begin
      drive_calc = dv[33] ? (NEUTRAL_DRIVE - {1'b0, fr_q}) : (NEUTRAL_DRIVE + {1'b0, fr_q});
    end else begin
      drive_calc = vc_q[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      joint_out <= joint_q;
      drive     <= (enable && in_range_q) ? drive_calc : NEUTRAL_DRIVE;
    end
  end

endmodule
